// ----- rtl/pdr_pkg.sv -----
// Package for the planar dead-reckoning pose block.
// Holds field widths, register indexes, CORDIC constants and the controller command struct.
// No dependencies.
package pdr_pkg;

	localparam int DIST_W    = 32;
	localparam int ANGLE_W   = 16;
	localparam int POS_W     = 48;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 2'd2;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;
	localparam int STEP_IDX_W       = 5;
	localparam int TURN_W           = 32;
	localparam int CV_W             = 33;
	localparam int PROD_W           = DIST_W + CV_W;
	localparam int INC_W            = PROD_W - 30;
	localparam logic signed [CV_W-1:0] CORDIC_GAIN = 33'sd652032874;

	typedef struct packed {
		logic                  start;
		logic                  rotate;
		logic                  mul_x;
		logic                  acc_x;
		logic                  mul_y;
		logic                  acc_y;
		logic                  emit;
		logic [STEP_IDX_W-1:0] step;
	} pdr_cmd_t;

	function automatic logic [TURN_W-1:0] atan_turn(input logic [STEP_IDX_W-1:0] i);
		logic [TURN_W-1:0] v;
		case (i)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933405;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335086;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41721;
			5'd15:   v = 32'd20860;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2607;
			5'd19:   v = 32'd1303;
			5'd20:   v = 32'd651;
			5'd21:   v = 32'd325;
			5'd22:   v = 32'd162;
			5'd23:   v = 32'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/planar_dead_reckoning_pose_top.sv -----
// Top level of the planar dead-reckoning pose block.
// Joins pdr_ctrl and pdr_dp; depends on pdr_pkg.
//
// Channel | Direction | Content
// s_*     | in        | request: delta_distance [31:0], delta_heading [47:32]
// m_*     | out       | result: pose_x [47:0], pose_y [95:48], pose_heading [111:96]
// cfg_*   | in        | start_x, start_y, start_heading writes, no read-back
//
// Each request passes through capture, CORDIC_STEPS rotations (at most 24) in the shared rotation
// stage, then two multiplies, the last accumulate and the result handoff.
// Requests are taken one at a time; the next is taken while the last result waits in m_*.
// A held result stalls the handoff of the following one, not its computation.
// Reset clears the start registers and pose to zero; any write to a mapped register reloads the pose.
module planar_dead_reckoning_pose_top #(
	parameter int CORDIC_STEPS = pdr_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [47:0]                       s_tdata,   // delta_distance, delta_heading
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [111:0]                      m_tdata,   // pose_x, pose_y, pose_heading
	input  logic                              cfg_we,
	input  logic [pdr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pdr_pkg::CFG_W-1:0]         cfg_data
);

	pdr_pkg::pdr_cmd_t                 cmd;
	logic [pdr_pkg::POS_W-1:0]         pose_x, pose_y;
	logic [pdr_pkg::ANGLE_W-1:0]       pose_heading;

	pdr_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	pdr_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.delta_distance (s_tdata[31:0]),
		.delta_heading  (s_tdata[47:32]),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pose_x         (pose_x),
		.pose_y         (pose_y),
		.pose_heading   (pose_heading)
	);

	assign m_tdata = {pose_heading, pose_y, pose_x};

endmodule

// ----- rtl/pdr_ctrl.sv -----
// Controller for the planar dead-reckoning pose block.
// Sequences start, CORDIC rotations, the two multiply-accumulates and the result handoff.
// Depends on pdr_pkg.
module pdr_ctrl #(
	parameter int CORDIC_STEPS = pdr_pkg::CORDIC_STEPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output pdr_pkg::pdr_cmd_t cmd
);

	localparam int STEPS_RUN = (CORDIC_STEPS < pdr_pkg::ATAN_ENTRIES) ?
		CORDIC_STEPS : pdr_pkg::ATAN_ENTRIES;
	localparam int STEP_W = (STEPS_RUN > 1) ? $clog2(STEPS_RUN) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT,
		ST_MULX,
		ST_MULY,
		ST_ACCY,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] cnt_q;
	logic              m_tvalid_q;
	logic              out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd        = '0;
		cmd.step   = pdr_pkg::STEP_IDX_W'(cnt_q);
		cmd.start  = (state_q == ST_IDLE) && s_tvalid;
		cmd.rotate = (state_q == ST_ROT);
		cmd.mul_x  = (state_q == ST_MULX);
		cmd.acc_x  = (state_q == ST_MULY);
		cmd.mul_y  = (state_q == ST_MULY);
		cmd.acc_y  = (state_q == ST_ACCY);
		cmd.emit   = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (s_tvalid)
						state_q <= ST_ROT;
				end
				ST_ROT: begin
					if (cnt_q == STEP_W'(STEPS_RUN - 1))
						state_q <= ST_MULX;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_MULX: state_q <= ST_MULY;
				ST_MULY: state_q <= ST_ACCY;
				ST_ACCY: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/pdr_dp.sv -----
// Datapath for the planar dead-reckoning pose block.
// Holds start registers, pose, shared CORDIC stage, one multiplier and the result register.
// Depends on pdr_pkg.
module pdr_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pdr_pkg::pdr_cmd_t                     cmd,
	input  logic signed [pdr_pkg::DIST_W-1:0]     delta_distance,
	input  logic signed [pdr_pkg::ANGLE_W-1:0]    delta_heading,
	input  logic                                  cfg_we,
	input  logic [pdr_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pdr_pkg::CFG_W-1:0]             cfg_data,
	output logic [pdr_pkg::POS_W-1:0]             pose_x,
	output logic [pdr_pkg::POS_W-1:0]             pose_y,
	output logic [pdr_pkg::ANGLE_W-1:0]           pose_heading
);

	localparam int CV_W   = pdr_pkg::CV_W;
	localparam int POS_W  = pdr_pkg::POS_W;
	localparam int TURN_W = pdr_pkg::TURN_W;

	logic signed [POS_W-1:0]            start_x_q, start_y_q;
	logic [pdr_pkg::ANGLE_W-1:0]        start_h_q;
	logic signed [POS_W-1:0]            cur_x_q, cur_y_q;
	logic [pdr_pkg::ANGLE_W-1:0]        cur_h_q;
	logic signed [pdr_pkg::DIST_W-1:0]  dist_q;
	logic [pdr_pkg::ANGLE_W-1:0]        dh_q;
	logic [1:0]                         quad_q;
	logic signed [CV_W-1:0]             cx_q, cy_q, z_q;
	logic signed [pdr_pkg::PROD_W-1:0]  prod_q;
	logic [POS_W-1:0]                   out_x_q, out_y_q;
	logic [pdr_pkg::ANGLE_W-1:0]        out_h_q;

	logic [TURN_W-1:0]                  phi, phi_rnd, rem;
	logic [1:0]                         quad;
	logic signed [CV_W-1:0]             xs, ys, atan_v;
	logic signed [CV_W-1:0]             cos_v, sin_v, mul_op;
	logic signed [pdr_pkg::PROD_W-1:0]  prod_rnd;
	logic signed [pdr_pkg::INC_W-1:0]   inc;
	logic signed [POS_W-1:0]            pos_sel, pos_new;
	logic signed [POS_W:0]              pos_sum;
	logic signed [POS_W-1:0]            nx_start_x, nx_start_y;
	logic [pdr_pkg::ANGLE_W-1:0]        nx_start_h;
	logic                               cfg_hit;

	assign phi     = {cur_h_q, 16'b0} + {delta_heading[15], delta_heading, 15'b0};
	assign phi_rnd = phi + 32'h2000_0000;
	assign quad    = phi_rnd[31:30];
	assign rem     = phi - {quad, 30'b0};

	assign xs     = cx_q >>> cmd.step;
	assign ys     = cy_q >>> cmd.step;
	assign atan_v = $signed({1'b0, pdr_pkg::atan_turn(cmd.step)});

	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_v = cx_q;
				sin_v = cy_q;
			end
			2'd1: begin
				cos_v = -cy_q;
				sin_v = cx_q;
			end
			2'd2: begin
				cos_v = -cx_q;
				sin_v = -cy_q;
			end
			default: begin
				cos_v = cy_q;
				sin_v = -cx_q;
			end
		endcase
	end

	assign mul_op   = cmd.mul_y ? sin_v : cos_v;
	assign prod_rnd = prod_q + (pdr_pkg::PROD_W)'(64'sd536870912);
	assign inc      = prod_rnd[pdr_pkg::PROD_W-1:30];
	assign pos_sel  = cmd.acc_y ? cur_y_q : cur_x_q;
	assign pos_sum  = {pos_sel[POS_W-1], pos_sel} + (POS_W + 1)'(inc);

	always_comb begin
		if (pos_sum[POS_W] != pos_sum[POS_W-1])
			pos_new = pos_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		else
			pos_new = pos_sum[POS_W-1:0];
	end

	always_comb begin
		nx_start_x = start_x_q;
		nx_start_y = start_y_q;
		nx_start_h = start_h_q;
		cfg_hit    = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				pdr_pkg::CFG_START_X: begin
					nx_start_x = cfg_data;
					cfg_hit    = 1'b1;
				end
				pdr_pkg::CFG_START_Y: begin
					nx_start_y = cfg_data;
					cfg_hit    = 1'b1;
				end
				pdr_pkg::CFG_START_HEADING: begin
					nx_start_h = cfg_data[pdr_pkg::ANGLE_W-1:0];
					cfg_hit    = 1'b1;
				end
				default: cfg_hit = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			start_h_q <= '0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			cur_h_q   <= '0;
		end else if (cfg_hit) begin
			start_x_q <= nx_start_x;
			start_y_q <= nx_start_y;
			start_h_q <= nx_start_h;
			cur_x_q   <= nx_start_x;
			cur_y_q   <= nx_start_y;
			cur_h_q   <= nx_start_h;
		end else begin
			if (cmd.acc_x)
				cur_x_q <= pos_new;
			if (cmd.acc_y) begin
				cur_y_q <= pos_new;
				cur_h_q <= cur_h_q + dh_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dist_q <= delta_distance;
			dh_q   <= delta_heading;
			quad_q <= quad;
			cx_q   <= pdr_pkg::CORDIC_GAIN;
			cy_q   <= '0;
			z_q    <= {rem[TURN_W-1], rem};
		end else if (cmd.rotate) begin
			if (!z_q[CV_W-1]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				z_q  <= z_q - atan_v;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				z_q  <= z_q + atan_v;
			end
		end
		if (cmd.mul_x || cmd.mul_y)
			prod_q <= dist_q * mul_op;
		if (cmd.emit) begin
			out_x_q <= cur_x_q;
			out_y_q <= cur_y_q;
			out_h_q <= cur_h_q;
		end
	end

	assign pose_x       = out_x_q;
	assign pose_y       = out_y_q;
	assign pose_heading = out_h_q;

endmodule

// ----- sim/tb_planar_dead_reckoning_pose_top.sv -----
// Self-checking testbench for planar_dead_reckoning_pose_top.
// Predicts each pose update with its own midpoint-rule CORDIC and checks every output field.
// Depends on pdr_pkg and the planar_dead_reckoning_pose_top RTL.
module tb_planar_dead_reckoning_pose_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = pdr_pkg::CORDIC_STEPS_DEF;
	localparam logic [pdr_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;
	localparam longint POS_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint POS_LO = -POS_HI - 1;
	localparam longint GAIN_Q30 = 652032874;
	localparam longint ATAN_TURN [0:23] = '{
		536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335086, 667544, 333772,
		166886, 83443, 41721, 20860, 10430, 5215,
		2607, 1303, 651, 325, 162, 81
	};

	typedef struct packed {
		logic [pdr_pkg::ANGLE_W-1:0] dh;
		logic [pdr_pkg::DIST_W-1:0]  dd;
	} odo_req_t;

	typedef struct packed {
		logic [pdr_pkg::ANGLE_W-1:0] h;
		logic [pdr_pkg::POS_W-1:0]   y;
		logic [pdr_pkg::POS_W-1:0]   x;
	} pose_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [47:0]                   s_tdata = '0;   // delta_distance, delta_heading
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [111:0]                  m_tdata;        // pose_x, pose_y, pose_heading
	logic                          cfg_we = 1'b0;
	logic [pdr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pdr_pkg::CFG_W-1:0]     cfg_data = '0;

	odo_req_t req_pending[$];
	pose_t    pose_expect[$];

	longint        start_x_q = 0, start_y_q = 0;
	logic [15:0]   start_h_q = '0;
	longint        dr_x = 0, dr_y = 0;
	logic [15:0]   dr_h = '0;

	int  errors = 0;
	int  reqs_taken = 0;
	int  results_seen = 0;
	int  cfg_writes = 0;
	bit  idle_on = 1'b1;
	int  src_gap = 0;
	int  sink_hold = 0;
	bit  long_hold_done = 1'b0;

	planar_dead_reckoning_pose_top #(.CORDIC_STEPS(STEPS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic longint clamp_pos(input longint v);
		if (v > POS_HI)
			return POS_HI;
		if (v < POS_LO)
			return POS_LO;
		return v;
	endfunction

	function automatic pose_t dead_reckon(input odo_req_t r);
		logic [31:0] dh_ext;
		logic [31:0] phi;
		logic [31:0] t;
		logic [31:0] rem_a;
		logic [1:0]  quad;
		longint      z, cx, cy, nx, c, s, dd;
		pose_t       p;
		dh_ext = {{16{r.dh[15]}}, r.dh};
		phi = {dr_h, 16'h0000} + (dh_ext << 15);
		t = phi + 32'h2000_0000;
		quad = t[31:30];
		rem_a = phi - {quad, 30'd0};
		z = longint'($signed(rem_a));
		cx = GAIN_Q30;
		cy = 0;
		for (int i = 0; i < STEPS && i < 24; i++) begin
			if (z >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				z = z - ATAN_TURN[i];
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				z = z + ATAN_TURN[i];
			end
			cx = nx;
		end
		case (quad)
			2'd0: begin c = cx;  s = cy;  end
			2'd1: begin c = -cy; s = cx;  end
			2'd2: begin c = -cx; s = -cy; end
			default: begin c = cy; s = -cx; end
		endcase
		dd = longint'($signed(r.dd));
		dr_x = clamp_pos(dr_x + ((dd * c + (64'sd1 <<< 29)) >>> 30));
		dr_y = clamp_pos(dr_y + ((dd * s + (64'sd1 <<< 29)) >>> 30));
		dr_h = dr_h + r.dh;
		p.x = dr_x[47:0];
		p.y = dr_y[47:0];
		p.h = dr_h;
		return p;
	endfunction

	task automatic write_reg(input logic [pdr_pkg::CFG_IDX_W-1:0] idx,
			input logic [pdr_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
		case (idx)
			pdr_pkg::CFG_START_X:       start_x_q = longint'($signed(val));
			pdr_pkg::CFG_START_Y:       start_y_q = longint'($signed(val));
			pdr_pkg::CFG_START_HEADING: start_h_q = val[15:0];
			default:                    return;
		endcase
		dr_x = start_x_q;
		dr_y = start_y_q;
		dr_h = start_h_q;
	endtask

	task automatic push_req(input logic [31:0] dd, input logic [15:0] dh);
		odo_req_t r;
		r.dd = dd;
		r.dh = dh;
		req_pending.push_back(r);
	endtask

	task automatic wait_drain(input int settle);
		do
			@(posedge clk);
		while (req_pending.size() != 0 || s_tvalid || pose_expect.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	function automatic logic [47:0] rand_start();
		logic [47:0] v;
		case ($urandom_range(0, 5))
			0: v = 48'h7FFF_FFFF_FFFF;
			1: v = 48'h8000_0000_0000;
			2, 3: v = {{16{1'b0}}, $urandom_range(0, 32'h00FF_FFFF)} - 48'h0000_0080_0000;
			default: v = 48'({$urandom(), $urandom()});
		endcase
		return v;
	endfunction

	function automatic odo_req_t rand_req();
		odo_req_t r;
		case ($urandom_range(0, 7))
			0: r.dd = $urandom();
			1: r.dd = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: r.dd = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
		endcase
		case ($urandom_range(0, 5))
			0: r.dh = 16'($urandom());
			1: r.dh = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: r.dh = 16'($urandom_range(0, 4096) - 2048);
		endcase
		return r;
	endfunction

	// Source side: present pending requests, predict on each accepted one.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				pose_expect.push_back(dead_reckon(odo_req_t'(s_tdata)));
				reqs_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (req_pending.size() != 0) begin
					s_tdata <= req_pending.pop_front();
					s_tvalid <= 1'b1;
					if (idle_on && $urandom_range(0, 3) == 0)
						src_gap = $urandom_range(1, 5);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side: compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		pose_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				got = pose_t'(m_tdata);
				if (pose_expect.size() == 0) begin
					$error("unexpected result %h", m_tdata);
					errors++;
				end else begin
					want = pose_expect.pop_front();
					if (got.x !== want.x) begin
						$error("pose_x expected %0d actual %0d", $signed(want.x), $signed(got.x));
						errors++;
					end
					if (got.y !== want.y) begin
						$error("pose_y expected %0d actual %0d", $signed(want.y), $signed(got.y));
						errors++;
					end
					if (got.h !== want.h) begin
						$error("pose_heading expected %0d actual %0d",
							$signed(want.h), $signed(got.h));
						errors++;
					end
				end
			end
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 320) begin
				long_hold_done = 1'b1;
				sink_hold = 299;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				sink_hold = $urandom_range(0, 4);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		odo_req_t r;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pose from reset: extremes, quarter turns and the wrap onto minus pi.
		push_req(32'h0000_0000, 16'h0000);
		push_req(32'h7FFF_FFFF, 16'h0000);
		push_req(32'h8000_0000, 16'h0000);
		push_req(32'h0001_0000, 16'h4000);
		push_req(32'h0001_0000, 16'h4000);
		push_req(32'h0001_0000, 16'h7FFF);
		push_req(32'h0001_0000, 16'h8000);
		push_req(32'h0000_0001, 16'h0001);
		push_req(32'hFFFF_FFFF, 16'hFFFF);
		push_req(32'h7FFF_FFFF, 16'h7FFF);
		push_req(32'h8000_0000, 16'h8000);
		push_req(32'h0001_0000, 16'h2000);
		push_req(32'h0000_0000, 16'hFFFF);
		wait_drain(30);

		// Saturate x high and y low.
		write_reg(pdr_pkg::CFG_START_X, 48'h7FFF_FFFF_FFFF);
		write_reg(pdr_pkg::CFG_START_Y, 48'h8000_0000_0000);
		write_reg(pdr_pkg::CFG_START_HEADING, 48'h0);
		push_req(32'h7FFF_FFFF, 16'h0000);
		push_req(32'h7FFF_FFFF, 16'hC000);
		push_req(32'h8000_0000, 16'h0000);
		wait_drain(30);

		// Saturate x low; then a write to an unmapped index must leave the pose alone.
		write_reg(pdr_pkg::CFG_START_X, 48'h8000_0000_0000);
		write_reg(pdr_pkg::CFG_START_Y, 48'h7FFF_FFFF_FFFF);
		write_reg(pdr_pkg::CFG_START_HEADING, {$urandom(), 16'h7FFF});
		push_req(32'h7FFF_FFFF, 16'h0000);
		push_req(32'h8000_0000, 16'h0002);
		wait_drain(30);
		write_reg(CFG_NONE, 48'({$urandom(), $urandom()}));
		push_req(32'h0001_0000, 16'h0000);
		push_req(32'h8000_0000, 16'h0001);
		wait_drain(30);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5)
				idle_on = 1'b0;
			case ($urandom_range(0, 2))
				0: begin
					write_reg(pdr_pkg::CFG_START_HEADING, 48'({$urandom(), $urandom()}));
					write_reg(pdr_pkg::CFG_START_X, rand_start());
					write_reg(pdr_pkg::CFG_START_Y, rand_start());
				end
				1: begin
					write_reg(pdr_pkg::CFG_START_Y, rand_start());
					write_reg(pdr_pkg::CFG_START_HEADING, 48'({$urandom(), $urandom()}));
					write_reg(pdr_pkg::CFG_START_X, rand_start());
				end
				default: begin
					write_reg(pdr_pkg::CFG_START_X, rand_start());
					write_reg(pdr_pkg::CFG_START_Y, rand_start());
					write_reg(pdr_pkg::CFG_START_HEADING, 48'({$urandom(), $urandom()}));
				end
			endcase
			for (int n = 0; n < 190; n++) begin
				r = rand_req();
				req_pending.push_back(r);
			end
			wait_drain(30);
		end

		repeat (40) @(posedge clk);
		if (pose_expect.size() != 0) begin
			$error("%0d predicted poses never arrived", pose_expect.size());
			errors++;
		end
		$display("Run: %0d odometer requests, %0d poses checked, %0d register writes.",
			reqs_taken, results_seen, cfg_writes);
		$display("Covered saturation at both ends, heading wrap, unmapped writes, long sink stall.");
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
